// ===== rtl/nrte_pkg.sv =====
package nrte_pkg;

	localparam int ByteW  = 8;
	localparam int DigitW = 4;
	localparam int PairW  = 7;
	localparam int IntvW  = 16;
	localparam int FieldW = 4;
	localparam int CountW = 3;
	localparam int NumDigits = 6;
	localparam int MarkW  = 2;
	localparam int PaddrW = 3;
	localparam int PdataW = 32;

	localparam logic [IntvW-1:0]  IntervalReset = 16'd300;
	localparam logic [IntvW-1:0]  SinceMax      = 16'hFFFF;
	localparam logic [FieldW-1:0] FieldNone     = 4'd0;
	localparam logic [FieldW-1:0] FieldTime     = 4'd1;
	localparam logic [FieldW-1:0] FieldStatus   = 4'd2;
	localparam logic [FieldW-1:0] FieldDate     = 4'd9;
	localparam logic [CountW-1:0] CountMax      = 3'd7;
	localparam logic [CountW-1:0] CountStore    = 3'd6;

	localparam logic [ByteW-1:0] ChDollar = 8'h24;
	localparam logic [ByteW-1:0] ChG      = 8'h47;
	localparam logic [ByteW-1:0] ChP      = 8'h50;
	localparam logic [ByteW-1:0] ChN      = 8'h4E;
	localparam logic [ByteW-1:0] ChR      = 8'h52;
	localparam logic [ByteW-1:0] ChM      = 8'h4D;
	localparam logic [ByteW-1:0] ChC      = 8'h43;
	localparam logic [ByteW-1:0] ChComma  = 8'h2C;
	localparam logic [ByteW-1:0] ChDot    = 8'h2E;
	localparam logic [ByteW-1:0] ChA      = 8'h41;
	localparam logic [ByteW-1:0] ChV      = 8'h56;
	localparam logic [ByteW-1:0] ChZ      = 8'h5A;
	localparam logic [ByteW-1:0] Ch0      = 8'h30;
	localparam logic [ByteW-1:0] Ch9      = 8'h39;

	// Register index, taken from paddr bit 2 (one register per 32-bit word).
	localparam logic RegSyncInterval = 1'b0;

	typedef enum logic [MarkW-1:0] {
		MARK_NONE    = 2'd0,
		MARK_VALID   = 2'd1,
		MARK_INVALID = 2'd2
	} mark_t;

	typedef enum logic [2:0] {
		HDR_DOLLAR = 3'd0,
		HDR_G      = 3'd1,
		HDR_TALKER = 3'd2,
		HDR_R      = 3'd3,
		HDR_M      = 3'd4,
		HDR_C      = 3'd5,
		HDR_COMMA  = 3'd6
	} hdr_state_t;

	typedef struct packed {
		logic             time_set;
		logic [PairW-1:0] hours;
		logic [PairW-1:0] minutes;
		logic [PairW-1:0] seconds;
		logic [PairW-1:0] day_of_month;
		logic [PairW-1:0] month_number;
		logic [PairW-1:0] year_of_century;
		logic [MarkW-1:0] valid_marker;
	} rsp_t;

	function automatic logic [PairW-1:0] dec_pair(input logic [DigitW-1:0] tens,
			input logic [DigitW-1:0] ones);
		dec_pair = PairW'(tens) * PairW'(10) + PairW'(ones);
	endfunction

endpackage

// ===== rtl/nrte_req_if.sv =====
interface nrte_req_if import nrte_pkg::*;;
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [ByteW-1:0] rx_byte;

	modport source (output valid, output req_type, output rx_byte, input ready);
	modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

// ===== rtl/nrte_rsp_if.sv =====
interface nrte_rsp_if import nrte_pkg::*;;
	logic             valid;
	logic             ready;
	logic             time_set;
	logic [PairW-1:0] hours;
	logic [PairW-1:0] minutes;
	logic [PairW-1:0] seconds;
	logic [PairW-1:0] day_of_month;
	logic [PairW-1:0] month_number;
	logic [PairW-1:0] year_of_century;
	logic [MarkW-1:0] valid_marker;

	modport source (output valid, output time_set, output hours, output minutes,
		output seconds, output day_of_month, output month_number,
		output year_of_century, output valid_marker, input ready);
	modport sink (input valid, input time_set, input hours, input minutes,
		input seconds, input day_of_month, input month_number,
		input year_of_century, input valid_marker, output ready);
endinterface

// ===== rtl/nmea_rmc_time_extractor.sv =====
// Each accepted item's result is registered in the output register.
// One item per cycle unless the output stalls; each gives exactly one result.
// A new item is taken while the output register drains in the same cycle.
// Reset (arst_n low, asynchronous) clears parser state, the pending flag and
// the output valid, sets the interval to 300 and the seconds counter to 65535.
module nmea_rmc_time_extractor import nrte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	nrte_req_if.sink          req,
	nrte_rsp_if.source        rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [PaddrW-1:0] paddr,
	input  logic [PdataW-1:0] pwdata,
	output logic [PdataW-1:0] prdata,
	output logic              pready
);

	logic [IntvW-1:0]  interval_q;
	hdr_state_t        hdr_q, hdr_d, hdr_next;
	logic              hdr_start;
	logic [FieldW-1:0] field_q, field_d;
	logic [CountW-1:0] count_q, count_d;
	logic [DigitW-1:0] time_q [NumDigits];
	logic [DigitW-1:0] time_d [NumDigits];
	logic [DigitW-1:0] date_q [NumDigits];
	logic [DigitW-1:0] date_d [NumDigits];
	logic [ByteW-1:0]  status_q, status_d;
	logic              pending_q, pending_d;
	logic [IntvW-1:0]  since_q, since_d;
	rsp_t              res_d, res_q;
	logic              rsp_valid_q;
	logic              accept;

	logic [ByteW-1:0]  b;
	logic              is_digit, kept, advance, elapsed;
	logic [FieldW-1:0] field_inc;

	assign b       = req.rx_byte;
	assign accept  = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegSyncInterval) ? PdataW'(interval_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= IntervalReset;
		end else if (psel && penable && pwrite && (paddr[2] == RegSyncInterval)) begin
			interval_q <= pwdata[IntvW-1:0];
		end
	end

	// Header matcher: next state
	always_comb begin
		unique case (hdr_q)
			HDR_DOLLAR: hdr_next = (b == ChDollar) ? HDR_G : HDR_DOLLAR;
			HDR_G:      hdr_next = (b == ChG) ? HDR_TALKER : HDR_DOLLAR;
			HDR_TALKER: hdr_next = (b == ChP || b == ChN) ? HDR_R : HDR_DOLLAR;
			HDR_R:      hdr_next = (b == ChR) ? HDR_M : HDR_DOLLAR;
			HDR_M:      hdr_next = (b == ChM) ? HDR_C : HDR_DOLLAR;
			HDR_C:      hdr_next = (b == ChC) ? HDR_COMMA : HDR_DOLLAR;
			default:    hdr_next = HDR_DOLLAR;
		endcase
	end

	// Header matcher: outputs
	always_comb begin
		unique case (hdr_q)
			HDR_COMMA: hdr_start = (b == ChComma);
			default:   hdr_start = 1'b0;
		endcase
	end

	assign is_digit  = (b >= Ch0) && (b <= Ch9);
	assign kept      = is_digit || (b == ChDot) || ((b >= ChA) && (b <= ChZ));
	assign elapsed   = since_q > interval_q;
	assign field_inc = field_q + FieldW'(1);

	always_comb begin
		hdr_d     = hdr_q;
		field_d   = field_q;
		count_d   = count_q;
		time_d    = time_q;
		date_d    = date_q;
		status_d  = status_q;
		pending_d = pending_q;
		since_d   = since_q;
		advance   = 1'b0;
		res_d     = '0;

		if (req.req_type) begin
			if (since_q != SinceMax) begin
				since_d = since_q + IntvW'(1);
			end
		end else begin
			if (field_q != FieldNone) begin
				if (b == ChV) begin
					// A 'V' empties the current field and moves on to the next one.
					if (field_q == FieldTime) time_d = '{default: '0};
					if (field_q == FieldStatus) status_d = '0;
					if (field_q == FieldDate) date_d = '{default: '0};
					advance = 1'b1;
				end else if (kept) begin
					if (count_q < CountStore) begin
						if (field_q == FieldTime) begin
							time_d[count_q] = is_digit ? b[DigitW-1:0] : '0;
						end else if (field_q == FieldDate) begin
							date_d[count_q] = is_digit ? b[DigitW-1:0] : '0;
						end else if (field_q == FieldStatus && count_q == '0) begin
							status_d = b;
						end
					end
					if (count_q != CountMax) count_d = count_q + CountW'(1);
				end else if (b == ChComma) begin
					advance = 1'b1;
				end

				if (advance) begin
					if (field_q >= FieldDate) begin
						field_d   = FieldNone;
						pending_d = 1'b1;
					end else begin
						field_d = field_inc;
						count_d = '0;
						if (field_inc == FieldTime) time_d = '{default: '0};
						if (field_inc == FieldStatus) status_d = '0;
						if (field_inc == FieldDate) date_d = '{default: '0};
					end
				end
			end else begin
				hdr_d = hdr_next;
				if (hdr_start) begin
					field_d = FieldTime;
					count_d = '0;
					time_d  = '{default: '0};
				end
			end

			// The sync check sees the state this byte leaves behind.
			if (field_d == FieldNone) begin
				if (pending_d && status_d == ChA && elapsed) begin
					res_d.time_set        = 1'b1;
					res_d.hours           = dec_pair(time_d[0], time_d[1]);
					res_d.minutes         = dec_pair(time_d[2], time_d[3]);
					res_d.seconds         = dec_pair(time_d[4], time_d[5]);
					res_d.day_of_month    = dec_pair(date_d[0], date_d[1]);
					res_d.month_number    = dec_pair(date_d[2], date_d[3]);
					res_d.year_of_century = dec_pair(date_d[4], date_d[5]);
					res_d.valid_marker    = MARK_VALID;
					pending_d = 1'b0;
					since_d   = '0;
				end else if (elapsed) begin
					res_d.valid_marker = MARK_INVALID;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q     <= HDR_DOLLAR;
			field_q   <= FieldNone;
			count_q   <= '0;
			time_q    <= '{default: '0};
			date_q    <= '{default: '0};
			status_q  <= '0;
			pending_q <= 1'b0;
			since_q   <= SinceMax;
		end else if (accept) begin
			hdr_q     <= hdr_d;
			field_q   <= field_d;
			count_q   <= count_d;
			time_q    <= time_d;
			date_q    <= date_d;
			status_q  <= status_d;
			pending_q <= pending_d;
			since_q   <= since_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.time_set        = res_q.time_set;
	assign rsp.hours           = res_q.hours;
	assign rsp.minutes         = res_q.minutes;
	assign rsp.seconds         = res_q.seconds;
	assign rsp.day_of_month    = res_q.day_of_month;
	assign rsp.month_number    = res_q.month_number;
	assign rsp.year_of_century = res_q.year_of_century;
	assign rsp.valid_marker    = res_q.valid_marker;

endmodule
